[design/film_tone_curve_pixel_unit_defines.svh]
// Assertion macros used by the checker file of this block.
`ifndef FILM_TONE_CURVE_PIXEL_UNIT_DEFINES_SVH
`define FILM_TONE_CURVE_PIXEL_UNIT_DEFINES_SVH

// Property checked while the block is out of reset.
`define FTC_ASSERT(NAME, PROP, MSG) \
    NAME: assert property (@(posedge i_clk) disable iff (!i_rst_n) PROP) else $error(MSG);

// Property that also has to hold across reset.
`define FTC_ASSERT_RST(NAME, PROP, MSG) \
    NAME: assert property (@(posedge i_clk) PROP) else $error(MSG);

`endif

[design/ftc_pkg.sv]
`default_nettype none

package ftc_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned CHAN_MAX = 255;

    typedef logic [CHAN_W-1:0] t_chan;

    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    // Luma datapath.
    localparam int unsigned LUMA_INDEX_BITS = 10;
    localparam int unsigned LUMA_BITS       = 24;
    localparam int unsigned LUMA_DEPTH      = 2 ** LUMA_INDEX_BITS;
    localparam int unsigned LUMA_W_R        = 19595;
    localparam int unsigned LUMA_W_G        = 38470;
    localparam int unsigned LUMA_W_B        = 7471;

    typedef logic [LUMA_INDEX_BITS-1:0] t_luma_idx;
    typedef logic [LUMA_BITS-1:0]       t_luma;

    // Gamma exponents as num/den.
    localparam int unsigned GAMMA_BW_NUM    = 9;
    localparam int unsigned GAMMA_BW_DEN    = 10;
    localparam int unsigned GAMMA_NEG_NUM   = 17;
    localparam int unsigned GAMMA_NEG_DEN   = 20;
    localparam int unsigned GAMMA_SLIDE_NUM = 6;
    localparam int unsigned GAMMA_SLIDE_DEN = 5;

    // Contrast arithmetic.
    localparam int unsigned CONTRAST_HIGH_MUL = 12;
    localparam int unsigned CONTRAST_LOW_MUL  = 8;
    localparam int unsigned CONTRAST_DIV      = 10;

    typedef enum logic [1:0] {
        FILM_BW    = 2'd0,
        FILM_NEG   = 2'd1,
        FILM_SLIDE = 2'd2
    } t_film_mode;

    typedef enum logic [1:0] {
        CONTRAST_NONE = 2'd0,
        CONTRAST_HIGH = 2'd1,
        CONTRAST_LOW  = 2'd2
    } t_contrast_mode;

    // Register file.
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned APB_DATA_W = 32;
    localparam int unsigned MODE_W     = 2;

    typedef enum logic [0:0] {
        REG_FILM_MODE     = 1'b0,
        REG_CONTRAST_MODE = 1'b1
    } t_reg_index;

    // Wide enough for t^den * d^num and n^num * 255^den on every curve.
    localparam int unsigned BIG_W = 320;
    typedef logic [BIG_W-1:0] t_big;

    typedef t_chan t_chan_lut [CHAN_MAX+1];
    typedef t_chan t_luma_lut [LUMA_DEPTH];

    // floor(255 * (n/d)^(num/den)) found exactly as the largest y with
    // y^den * d^num <= n^num * 255^den. Evaluated only while building tables.
    function automatic t_chan gamma_entry(input int unsigned n, input int unsigned d,
                                          input int unsigned num, input int unsigned den);
        t_big  rhs;
        t_big  lhs;
        t_chan y;
        t_chan t;
        rhs = t_big'(1);
        for (int unsigned k = 0; k < num; k++) rhs = rhs * t_big'(n);
        for (int unsigned k = 0; k < den; k++) rhs = rhs * t_big'(CHAN_MAX);
        y = '0;
        for (int b = CHAN_W - 1; b >= 0; b--) begin
            t = y | (t_chan'(1) << b);
            lhs = t_big'(1);
            for (int unsigned k = 0; k < den; k++) lhs = lhs * t_big'(t);
            for (int unsigned k = 0; k < num; k++) lhs = lhs * t_big'(d);
            if (lhs <= rhs) y = t;
        end
        return y;
    endfunction

    function automatic t_chan_lut build_chan_lut(input int unsigned num,
                                                 input int unsigned den);
        t_chan_lut lut;
        for (int unsigned i = 0; i <= CHAN_MAX; i++) begin
            lut[i] = gamma_entry(i, CHAN_MAX, num, den);
        end
        return lut;
    endfunction

    function automatic t_luma_lut build_luma_lut();
        t_luma_lut lut;
        for (int unsigned i = 0; i < LUMA_DEPTH; i++) begin
            lut[i] = gamma_entry(i, LUMA_DEPTH - 1, GAMMA_BW_NUM, GAMMA_BW_DEN);
        end
        return lut;
    endfunction

    function automatic t_chan contrast_entry(input int unsigned v, input t_contrast_mode mode);
        int unsigned t;
        t = v;
        if (mode == CONTRAST_HIGH) begin
            t = CONTRAST_HIGH_MUL * v;
            if (t <= CHAN_MAX) t = 0;
            else t = (t - CHAN_MAX) / CONTRAST_DIV;
        end else if (mode == CONTRAST_LOW) begin
            t = (CONTRAST_LOW_MUL * v + CHAN_MAX) / CONTRAST_DIV;
        end
        if (t > CHAN_MAX) t = CHAN_MAX;
        return t_chan'(t);
    endfunction

    function automatic t_chan_lut build_contrast_lut(input t_contrast_mode mode);
        t_chan_lut lut;
        for (int unsigned i = 0; i <= CHAN_MAX; i++) begin
            lut[i] = contrast_entry(i, mode);
        end
        return lut;
    endfunction

    localparam t_luma_lut LUMA_LUT  = build_luma_lut();
    localparam t_chan_lut NEG_LUT   = build_chan_lut(GAMMA_NEG_NUM, GAMMA_NEG_DEN);
    localparam t_chan_lut SLIDE_LUT = build_chan_lut(GAMMA_SLIDE_NUM, GAMMA_SLIDE_DEN);
    localparam t_chan_lut HIGH_LUT  = build_contrast_lut(CONTRAST_HIGH);
    localparam t_chan_lut LOW_LUT   = build_contrast_lut(CONTRAST_LOW);

endpackage

`default_nettype wire

[design/ftc_pix_in_if.sv]
`default_nettype none

interface ftc_pix_in_if import ftc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_chan red_in;
    t_chan green_in;
    t_chan blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

`default_nettype wire

[design/ftc_pix_out_if.sv]
`default_nettype none

interface ftc_pix_out_if import ftc_pkg::*; ();
    logic  valid;
    logic  ready;
    t_chan red_out;
    t_chan green_out;
    t_chan blue_out;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    output ready);
endinterface

`default_nettype wire

[design/ftc_luma.sv]
`default_nettype none

module ftc_luma import ftc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_en,
    input  t_rgb      i_pix,
    output t_luma_idx o_idx,
    output t_rgb      o_pix
);

    t_luma     n_luma;
    t_luma_idx r_idx;
    t_rgb      r_pix;

    // Weighted sum never exceeds 255 * 2^16, so the top bits never overflow the table.
    always_comb begin
        n_luma = t_luma'(LUMA_W_R) * t_luma'(i_pix.red)
               + t_luma'(LUMA_W_G) * t_luma'(i_pix.green)
               + t_luma'(LUMA_W_B) * t_luma'(i_pix.blue);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_idx <= n_luma[LUMA_BITS-1 -: LUMA_INDEX_BITS];
            r_pix <= i_pix;
        end
    end

    assign o_idx = r_idx;
    assign o_pix = r_pix;

endmodule

`default_nettype wire

[design/ftc_tone.sv]
`default_nettype none

module ftc_tone import ftc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [MODE_W-1:0] i_film_mode,
    input  t_luma_idx    i_idx,
    input  t_rgb         i_pix,
    output logic         o_bw,
    output t_chan        o_luma_y,
    output t_rgb         o_pix
);

    t_rgb  n_pix;
    t_rgb  r_pix;
    t_chan r_luma_y;
    logic  r_bw;

    always_comb begin
        case (i_film_mode)
            FILM_NEG: begin
                n_pix.red   = NEG_LUT[i_pix.red];
                n_pix.green = NEG_LUT[i_pix.green];
                n_pix.blue  = NEG_LUT[i_pix.blue];
            end
            FILM_SLIDE: begin
                n_pix.red   = SLIDE_LUT[i_pix.red];
                n_pix.green = SLIDE_LUT[i_pix.green];
                n_pix.blue  = SLIDE_LUT[i_pix.blue];
            end
            default: begin
                n_pix = i_pix;
            end
        endcase
    end

    // The luma curve is a ROM with a registered read.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_luma_y <= LUMA_LUT[i_idx];
            r_pix    <= n_pix;
            r_bw     <= (i_film_mode == FILM_BW);
        end
    end

    assign o_bw     = r_bw;
    assign o_luma_y = r_luma_y;
    assign o_pix    = r_pix;

endmodule

`default_nettype wire

[design/ftc_contrast.sv]
`default_nettype none

module ftc_contrast import ftc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_en,
    input  logic [MODE_W-1:0] i_contrast_mode,
    input  logic         i_bw,
    input  t_chan        i_luma_y,
    input  t_rgb         i_pix,
    output t_rgb         o_pix
);

    t_rgb tone_pix;
    t_rgb n_pix;
    t_rgb r_pix;

    function automatic t_chan apply_contrast(input t_chan v, input logic [MODE_W-1:0] mode);
        t_chan res;
        case (mode)
            CONTRAST_HIGH: res = HIGH_LUT[v];
            CONTRAST_LOW:  res = LOW_LUT[v];
            default:       res = v;
        endcase
        return res;
    endfunction

    always_comb begin
        if (i_bw) begin
            tone_pix = '{red: i_luma_y, green: i_luma_y, blue: i_luma_y};
        end else begin
            tone_pix = i_pix;
        end
        n_pix.red   = apply_contrast(tone_pix.red, i_contrast_mode);
        n_pix.green = apply_contrast(tone_pix.green, i_contrast_mode);
        n_pix.blue  = apply_contrast(tone_pix.blue, i_contrast_mode);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pix <= n_pix;
        end
    end

    assign o_pix = r_pix;

endmodule

`default_nettype wire

[design/film_tone_curve_pixel_unit.sv]
// Throughput: one pixel per clock cycle while the output is ready; four register stages
// (input, luma index, tone-curve ROM read, contrast output) each hold one pixel.
// Reset: synchronous, active low; clears all stage valid flags and both mode registers
// to black-and-white with no contrast. Datapath registers are not reset.
`default_nettype none

module film_tone_curve_pixel_unit import ftc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ftc_pix_in_if.sink            i_pix,
    ftc_pix_out_if.source         o_pix,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    // ------------------------------------------------------------------
    // Configuration registers. Register i sits at byte address 4*i, so the
    // register index is the address bit above the word offset. Writes are
    // expected only while the pipeline is empty.
    // ------------------------------------------------------------------
    logic [MODE_W-1:0] r_film_mode;
    logic [MODE_W-1:0] r_contrast_mode;
    logic              cfg_write;
    t_reg_index        cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = t_reg_index'(paddr[PADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_film_mode     <= MODE_W'(FILM_BW);
            r_contrast_mode <= MODE_W'(CONTRAST_NONE);
        end else if (cfg_write) begin
            case (cfg_index)
                REG_FILM_MODE:     r_film_mode     <= pwdata[MODE_W-1:0];
                REG_CONTRAST_MODE: r_contrast_mode <= pwdata[MODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            REG_FILM_MODE:     prdata = APB_DATA_W'(r_film_mode);
            REG_CONTRAST_MODE: prdata = APB_DATA_W'(r_contrast_mode);
            default:           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. Each stage loads when it is empty or when the
    // stage after it moves on, so bubbles are squeezed out and new pixels
    // keep entering while a finished pixel waits on the output, until every stage is full.
    // ------------------------------------------------------------------
    logic r_s1_vld;
    logic r_s2_vld;
    logic r_s3_vld;
    logic r_s4_vld;
    logic s1_rdy;
    logic s2_rdy;
    logic s3_rdy;
    logic s4_rdy;

    assign s4_rdy = !r_s4_vld || o_pix.ready;
    assign s3_rdy = !r_s3_vld || s4_rdy;
    assign s2_rdy = !r_s2_vld || s3_rdy;
    assign s1_rdy = !r_s1_vld || s2_rdy;

    assign i_pix.ready = s1_rdy;
    assign o_pix.valid = r_s4_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
        end else begin
            if (s1_rdy) r_s1_vld <= i_pix.valid;
            if (s2_rdy) r_s2_vld <= r_s1_vld;
            if (s3_rdy) r_s3_vld <= r_s2_vld;
            if (s4_rdy) r_s4_vld <= r_s3_vld;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: input register, loaded on every transaction of the input channel.
    // ------------------------------------------------------------------
    t_rgb r_s1_pix;

    always_ff @(posedge i_clk) begin
        if (s1_rdy) begin
            r_s1_pix <= '{red: i_pix.red_in, green: i_pix.green_in, blue: i_pix.blue_in};
        end
    end

    // Stage 2: BT.601 luma with 16-bit weights, reduced to the curve index.
    t_luma_idx s2_idx;
    t_rgb      s2_pix;

    ftc_luma u_luma (
        .i_clk (i_clk),
        .i_en  (s2_rdy),
        .i_pix (r_s1_pix),
        .o_idx (s2_idx),
        .o_pix (s2_pix)
    );

    // Stage 3: tone curves. The luma curve is read from its ROM; the color
    // negative and slide curves are looked up per channel.
    logic  s3_bw;
    t_chan s3_luma_y;
    t_rgb  s3_pix;

    ftc_tone u_tone (
        .i_clk       (i_clk),
        .i_en        (s3_rdy),
        .i_film_mode (r_film_mode),
        .i_idx       (s2_idx),
        .i_pix       (s2_pix),
        .o_bw        (s3_bw),
        .o_luma_y    (s3_luma_y),
        .o_pix       (s3_pix)
    );

    // Stage 4: black-and-white fan-out and the optional contrast curve,
    // landing in the output register.
    t_rgb s4_pix;

    ftc_contrast u_contrast (
        .i_clk           (i_clk),
        .i_en            (s4_rdy),
        .i_contrast_mode (r_contrast_mode),
        .i_bw            (s3_bw),
        .i_luma_y        (s3_luma_y),
        .i_pix           (s3_pix),
        .o_pix           (s4_pix)
    );

    assign o_pix.red_out   = s4_pix.red;
    assign o_pix.green_out = s4_pix.green;
    assign o_pix.blue_out  = s4_pix.blue;

endmodule

`default_nettype wire

[design/ftc_checker.sv]
`default_nettype none

`include "film_tone_curve_pixel_unit_defines.svh"

module ftc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_red,
    input logic [7:0] i_out_green,
    input logic [7:0] i_out_blue
);

    // Reset empties the pipeline.
    `FTC_ASSERT_RST(a_reset_empty, !i_rst_n |=> !i_out_valid, "output valid after reset")

    // With nothing waiting on the output the whole pipeline can move.
    `FTC_ASSERT(a_ready_when_idle,
        !i_out_valid |-> i_in_ready, "input stalled with empty output")

    // An accepted pixel reaches the output when the output side keeps taking.
    `FTC_ASSERT(a_latency,
        (i_in_valid && i_in_ready) ##1 i_out_ready ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid, "pixel not delivered on time")

    // A stalled result holds.
    `FTC_ASSERT(a_out_hold,
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_red)
        && $stable(i_out_green) && $stable(i_out_blue), "stalled output changed")

endmodule

bind film_tone_curve_pixel_unit ftc_checker u_ftc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.red_out),
    .i_out_green (o_pix.green_out),
    .i_out_blue  (o_pix.blue_out)
);

`default_nettype wire

[dv/film_tone_curve_pixel_unit_tb.sv]
`default_nettype none

module film_tone_curve_pixel_unit_tb;
    import ftc_pkg::*;

    // Clock, watchdog and end-of-run settling. The block holds four pipeline
    // stages, so the END_SETTLE wait after the last result is plenty.
    localparam int unsigned IDLE_LIMIT = 2000;
    localparam int unsigned END_SETTLE = 8;
    localparam int unsigned MAX_REPORTS = 20;

    // Mode encodings that the package enums do not name. Both must behave as
    // "no stage": the pixel passes through the tone curve or the contrast untouched.
    localparam logic [1:0] FILM_PASSTHRU  = 2'd3;
    localparam logic [1:0] CONTRAST_SPARE = 2'd3;

    // BT.601 luma weights in unsigned 0.16 form; they sum to exactly 65536.
    localparam int unsigned WEIGHT_R = 19595;
    localparam int unsigned WEIGHT_G = 38470;
    localparam int unsigned WEIGHT_B = 7471;
    // The 24-bit luma is cut down to a 10-bit curve index.
    localparam int unsigned LUMA_SHIFT = 14;
    localparam int unsigned LUMA_TOP   = 1023;
    localparam int unsigned FULL_SCALE = 255;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    ftc_pix_in_if  pix_in ();
    ftc_pix_out_if pix_out ();

    film_tone_curve_pixel_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Our own copy of the two mode registers, updated by set_tone after each of
    // its writes. The prediction reads these.
    logic [1:0] tone_film;
    logic [1:0] tone_contrast;

    // Gamma curves, built once at time zero by exact integer comparison.
    t_chan bw_curve    [LUMA_TOP+1];
    t_chan neg_curve   [FULL_SCALE+1];
    t_chan slide_curve [FULL_SCALE+1];

    // Processed pixels still owed by the block, oldest first.
    t_rgb expected_pixels [$];

    int unsigned error_count;
    int unsigned pixels_sent;
    int unsigned pixels_checked;
    int unsigned mode_writes;
    int unsigned idle_cycles;

    // Traffic shaping. When steady_source is set the sender never pauses, and
    // when steady_sink is set the receiver never stalls.
    int unsigned burst_left;
    bit          steady_source;
    bit          steady_sink;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // True when (cand/255)^den <= (n/d)^num, i.e. cand^den * d^num <= n^num * 255^den.
    // The negative curve needs close to 300 bits, hence the wide words.
    function automatic bit power_fits(input int unsigned cand, input int unsigned n,
                                      input int unsigned d, input int unsigned num,
                                      input int unsigned den);
        logic [383:0] lhs;
        logic [383:0] rhs;
        lhs = 384'd1;
        rhs = 384'd1;
        repeat (den) lhs = lhs * cand;
        repeat (num) lhs = lhs * d;
        repeat (num) rhs = rhs * n;
        repeat (den) rhs = rhs * FULL_SCALE;
        return lhs <= rhs;
    endfunction

    // The curves rise monotonically, so each entry starts its search from the
    // entry below it and climbs while the next code still fits under the curve.
    function automatic t_chan climb_curve(input t_chan start, input int unsigned n,
                                          input int unsigned d, input int unsigned num,
                                          input int unsigned den);
        t_chan y;
        y = start;
        while (y != 8'hFF && power_fits(int'(y) + 1, n, d, num, den)) y++;
        return y;
    endfunction

    task automatic build_curves();
        bw_curve[0]    = climb_curve(8'd0, 0, LUMA_TOP, 9, 10);
        neg_curve[0]   = climb_curve(8'd0, 0, FULL_SCALE, 17, 20);
        slide_curve[0] = climb_curve(8'd0, 0, FULL_SCALE, 6, 5);
        for (int unsigned i = 1; i <= LUMA_TOP; i++) begin
            bw_curve[i] = climb_curve(bw_curve[i-1], i, LUMA_TOP, 9, 10);
        end
        for (int unsigned i = 1; i <= FULL_SCALE; i++) begin
            neg_curve[i]   = climb_curve(neg_curve[i-1], i, FULL_SCALE, 17, 20);
            slide_curve[i] = climb_curve(slide_curve[i-1], i, FULL_SCALE, 6, 5);
        end
    endtask

    // High contrast stretches around mid-gray and clips at both ends; low
    // contrast compresses toward mid-gray and never leaves 0..255.
    function automatic t_chan contrast_adjust(input t_chan v, input logic [1:0] mode);
        int unsigned t;
        t = v;
        if (mode == CONTRAST_HIGH) begin
            t = 12 * v;
            if (t <= FULL_SCALE) return 8'd0;
            t = (t - FULL_SCALE) / 10;
            if (t > FULL_SCALE) t = FULL_SCALE;
        end else if (mode == CONTRAST_LOW) begin
            t = (8 * v + FULL_SCALE) / 10;
        end
        return t_chan'(t);
    endfunction

    function automatic t_rgb graded_pixel(input t_rgb px);
        t_chan       ch [3];
        int unsigned luma;
        t_rgb        res;
        ch[0] = px.red;
        ch[1] = px.green;
        ch[2] = px.blue;
        case (tone_film)
            FILM_BW: begin
                luma  = WEIGHT_R * px.red + WEIGHT_G * px.green + WEIGHT_B * px.blue;
                ch[0] = bw_curve[10'(luma >> LUMA_SHIFT)];
                ch[1] = ch[0];
                ch[2] = ch[0];
            end
            FILM_NEG: begin
                for (int k = 0; k < 3; k++) ch[k] = neg_curve[ch[k]];
            end
            FILM_SLIDE: begin
                for (int k = 0; k < 3; k++) ch[k] = slide_curve[ch[k]];
            end
            default: ;
        endcase
        for (int k = 0; k < 3; k++) ch[k] = contrast_adjust(ch[k], tone_contrast);
        res.red   = ch[0];
        res.green = ch[1];
        res.blue  = ch[2];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    task automatic compare_channel(input string name, input t_chan want, input t_chan got);
        if (got !== want) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            end
        end
    endtask

    // Every output transaction is matched against the oldest outstanding pixel.
    // Sampling happens at the clock edge, before any of this edge's updates land.
    always @(posedge i_clk) begin : check_results
        t_rgb want;
        if (i_rst_n && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
            if (expected_pixels.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS) begin
                    $display("%0t: unexpected pixel, expected none, actual %0d/%0d/%0d",
                             $time, pix_out.red_out, pix_out.green_out, pix_out.blue_out);
                end
            end else begin
                want = expected_pixels.pop_front();
                compare_channel("red_out", want.red, pix_out.red_out);
                compare_channel("green_out", want.green, pix_out.green_out);
                compare_channel("blue_out", want.blue, pix_out.blue_out);
                pixels_checked++;
            end
        end
    end

    // The watchdog restarts on any accepted transaction: pixel in, pixel out
    // or register access. A hang anywhere ends the run as a failure.
    always @(posedge i_clk) begin
        if (!i_rst_n || (pix_in.valid && pix_in.ready) || (pix_out.valid && pix_out.ready)
            || (psel && penable && pready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: watchdog expired, no transaction for %0d cycles, %0d pixels owed",
                     $time, idle_cycles, expected_pixels.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Output back-pressure
    // ------------------------------------------------------------------------

    // The receiver switches between styles in windows of random length: always
    // ready, coin-flip ready, a periodic one-in-three stall, and random-length runs of
    // stall alternating with random-length runs of ready.
    initial begin : sink_pattern
        int unsigned window;
        int unsigned style;
        int unsigned run;
        bit          stalled;
        window  = 0;
        style   = 0;
        run     = 0;
        stalled = 1'b0;
        pix_out.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (window == 0) begin
                window = $urandom_range(16, 96);
                style  = $urandom_range(0, 3);
            end
            window--;
            if (steady_sink) begin
                pix_out.ready <= 1'b1;
            end else begin
                case (style)
                    0: pix_out.ready <= 1'b1;
                    1: pix_out.ready <= 1'($urandom_range(0, 1));
                    2: pix_out.ready <= (window % 3) != 0;
                    default: begin
                        if (run == 0) begin
                            run     = $urandom_range(1, 16);
                            stalled = !stalled;
                        end
                        run--;
                        pix_out.ready <= !stalled;
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers. Every task starts and ends right after a rising edge.
    // ------------------------------------------------------------------------

    // Sends one pixel. Between bursts the sender drops valid for a random gap
    // and drives junk on the channels, which the block must ignore.
    task automatic send_pixel(input t_rgb px);
        int unsigned gap;
        if (!steady_source && burst_left == 0) begin
            gap = $urandom_range(1, 8);
            pix_in.valid    <= 1'b0;
            pix_in.red_in   <= t_chan'($urandom);
            pix_in.green_in <= t_chan'($urandom);
            pix_in.blue_in  <= t_chan'($urandom);
            repeat (gap) @(posedge i_clk);
            burst_left = $urandom_range(1, 30);
        end
        pix_in.valid    <= 1'b1;
        pix_in.red_in   <= px.red;
        pix_in.green_in <= px.green;
        pix_in.blue_in  <= px.blue;
        @(posedge i_clk);
        while (pix_in.ready !== 1'b1) @(posedge i_clk);
        expected_pixels.push_back(graded_pixel(px));
        pixels_sent++;
        if (burst_left != 0) burst_left--;
    endtask

    // Stops the input stream and waits for every owed pixel to come out.
    // The loop always waits on a clock edge before it checks, so the next driver starts a fresh step.
    task automatic wait_for_drain();
        pix_in.valid <= 1'b0;
        do @(posedge i_clk); while (expected_pixels.size() != 0);
    endtask

    // One write transaction: a setup phase, then an access phase that ends at
    // the edge where pready is seen high. An idle phase follows.
    task automatic reg_write(input t_reg_index idx, input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic reg_read(input t_reg_index idx, output logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_register(input t_reg_index idx, input logic [1:0] want);
        logic [APB_DATA_W-1:0] got;
        reg_read(idx, got);
        if (got !== APB_DATA_W'(want)) begin
            error_count++;
            if (error_count <= MAX_REPORTS) begin
                $display("%0t: register %s readback, expected %0d, actual %0h",
                         $time, idx.name(), want, got);
            end
        end
    endtask

    // Writes both modes with random junk in the unused upper data bits, which
    // the block must drop, and reads them back. Only called with the pipeline
    // empty.
    task automatic set_tone(input logic [1:0] film, input logic [1:0] contrast);
        reg_write(REG_FILM_MODE, {30'($urandom), film} & 32'hFFFF_FFF3);
        tone_film = film;
        reg_write(REG_CONTRAST_MODE, {30'($urandom), contrast} & 32'hFFFF_FFF3);
        tone_contrast = contrast;
        mode_writes += 2;
        check_register(REG_FILM_MODE, film);
        check_register(REG_CONTRAST_MODE, contrast);
    endtask

    // Channels lean toward the black and white rails and toward the dark and bright codes
    // where high contrast crosses from clipped to live and from live to saturated.
    function automatic t_chan random_channel();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return t_chan'($urandom_range(0, 31));
            3:       return t_chan'($urandom_range(224, 255));
            default: return t_chan'($urandom);
        endcase
    endfunction

    function automatic t_rgb random_pixel();
        t_rgb px;
        px.red   = random_channel();
        px.green = random_channel();
        px.blue  = random_channel();
        return px;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Reset values first, then every encoding of both registers, with the
    // unused data bits driven all-ones once and all-zeros once.
    task automatic test_register_access();
        check_register(REG_FILM_MODE, FILM_BW);
        check_register(REG_CONTRAST_MODE, CONTRAST_NONE);
        reg_write(REG_FILM_MODE, 32'hFFFF_FFFE);
        reg_write(REG_CONTRAST_MODE, 32'hFFFF_FFFD);
        check_register(REG_FILM_MODE, FILM_SLIDE);
        check_register(REG_CONTRAST_MODE, CONTRAST_HIGH);
        reg_write(REG_FILM_MODE, 32'h0000_0003);
        reg_write(REG_CONTRAST_MODE, 32'h0000_0003);
        check_register(REG_FILM_MODE, FILM_PASSTHRU);
        check_register(REG_CONTRAST_MODE, CONTRAST_SPARE);
        mode_writes += 4;
        set_tone(FILM_NEG, CONTRAST_LOW);
        set_tone(FILM_BW, CONTRAST_NONE);
    endtask

    // Hand-picked pixels: the rails, pure primaries, and the codes around the
    // clipping points of the high-contrast stage.
    task automatic test_directed_pixels();
        // Black-and-white without contrast: black must stay black, white must
        // land on curve index 1020, just short of the top, and each primary weights differently.
        set_tone(FILM_BW, CONTRAST_NONE);
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd255, 8'd0, 8'd0});
        send_pixel({8'd0, 8'd255, 8'd0});
        send_pixel({8'd0, 8'd0, 8'd255});
        send_pixel({8'd1, 8'd1, 8'd1});
        send_pixel({8'd128, 8'd128, 8'd128});
        wait_for_drain();

        // Negative curve into high contrast.
        set_tone(FILM_NEG, CONTRAST_HIGH);
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd1, 8'd2, 8'd3});
        wait_for_drain();

        // Slide curve into low contrast: black lifts, white drops.
        set_tone(FILM_SLIDE, CONTRAST_LOW);
        send_pixel({8'd0, 8'd0, 8'd0});
        send_pixel({8'd255, 8'd255, 8'd255});
        send_pixel({8'd128, 8'd64, 8'd192});
        wait_for_drain();

        // The unused film mode skips the tone curve, so high contrast sees the
        // raw codes: 21 and 22 clip to black, 23 is the first live code, 234 is the
        // first code that reaches white, and 235 is the first that clips there.
        set_tone(FILM_PASSTHRU, CONTRAST_HIGH);
        send_pixel({8'd21, 8'd22, 8'd23});
        send_pixel({8'd234, 8'd235, 8'd255});
        wait_for_drain();

        // Both unused encodings: the pixel must come out exactly as it went in.
        set_tone(FILM_PASSTHRU, CONTRAST_SPARE);
        send_pixel({8'h55, 8'hAA, 8'h0F});
        send_pixel({8'hF0, 8'h0F, 8'hFF});
        wait_for_drain();
    endtask

    // Every film mode against every contrast mode, in shuffled order, with
    // random pixels under random source gaps and sink stalls.
    task automatic test_mode_sweep();
        int unsigned order [16];
        int unsigned j;
        int unsigned tmp;
        for (int unsigned i = 0; i < 16; i++) order[i] = i;
        for (int unsigned i = 15; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        for (int unsigned i = 0; i < 16; i++) begin
            set_tone(order[i][3:2], order[i][1:0]);
            repeat (70) send_pixel(random_pixel());
            wait_for_drain();
        end
    endtask

    // Back-to-back pixels with the receiver always ready: the block has to
    // sustain one pixel per clock. Then the source runs flat out against a
    // stalling receiver to fill the pipeline.
    task automatic test_full_rate();
        set_tone(FILM_BW, CONTRAST_HIGH);
        steady_source = 1'b1;
        steady_sink   = 1'b1;
        repeat (60) send_pixel(random_pixel());
        steady_sink = 1'b0;
        repeat (60) send_pixel(random_pixel());
        steady_source = 1'b0;
        wait_for_drain();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n         <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        pix_in.valid    <= 1'b0;
        pix_in.red_in   <= '0;
        pix_in.green_in <= '0;
        pix_in.blue_in  <= '0;
        tone_film      = FILM_BW;
        tone_contrast  = CONTRAST_NONE;
        error_count    = 0;
        pixels_sent    = 0;
        pixels_checked = 0;
        mode_writes    = 0;
        idle_cycles    = 0;
        burst_left     = 0;
        steady_source  = 1'b0;
        steady_sink    = 1'b0;
        build_curves();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_register_access();
        test_directed_pixels();
        test_mode_sweep();
        test_full_rate();

        wait_for_drain();
        repeat (END_SETTLE) @(posedge i_clk);

        $display("Run covered %0d pixels sent and %0d checked, %0d mode register writes,",
                 pixels_sent, pixels_checked, mode_writes);
        $display("all four film encodings against all four contrast encodings.");
        if (error_count == 0 && expected_pixels.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d pixels never delivered",
                     error_count, expected_pixels.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

[sim.f]
+incdir+design
design/ftc_pkg.sv
design/ftc_pix_in_if.sv
design/ftc_pix_out_if.sv
design/ftc_luma.sv
design/ftc_tone.sv
design/ftc_contrast.sv
design/film_tone_curve_pixel_unit.sv
design/ftc_checker.sv
dv/film_tone_curve_pixel_unit_tb.sv
